@@ rtl/lne_pkg.sv @@
package lne_pkg;

  // Default highest ordinal of a long name
  localparam int unsigned MAX_ORDINAL_DEF = 20;

  // Characters per long-name entry
  localparam int unsigned SEG_CHARS = 13;

  localparam logic [7:0]  LAST_FLAG = 8'h40;
  localparam logic [15:0] PAD_CHAR  = 16'hFFFF;
  localparam logic [4:0]  COUNT_MAX = 5'd31;

  // index / 13 as (index * ROW_RECIP) >> ROW_SHIFT, exact for 9-bit indices
  localparam logic [11:0] ROW_RECIP = 12'd2521;
  localparam int unsigned ROW_SHIFT = 15;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_BUILD = 2'd3
  } action_t;

  // One name segment, character 0 in the lowest bits
  typedef logic [SEG_CHARS-1:0][15:0] seg_t;

  localparam int unsigned IN_W  = 240;
  localparam int unsigned OUT_W = 256;

  // Input request payload, first field lowest
  typedef struct packed {
    logic [5:0]  pad;
    logic        build_is_last;
    logic [8:0]  char_index;
    logic [15:0] char_last;
    logic [63:0] chars_third;
    logic [63:0] chars_second;
    logic [63:0] chars_first;
    logic [7:0]  name_checksum;
    logic [7:0]  ordinal_byte;
  } in_data_t;

  // Result payload, first field lowest
  typedef struct packed {
    logic [5:0]  pad;
    logic [15:0] read_char;
    logic [15:0] built_char_last;
    logic [63:0] built_chars_third;
    logic [63:0] built_chars_second;
    logic [63:0] built_chars_first;
    logic [7:0]  built_ordinal_byte;
    logic [7:0]  held_checksum;
    logic [4:0]  held_ordinal;
    logic [4:0]  entry_count;
  } out_data_t;

endpackage

@@ rtl/long_name_entry_assembler.sv @@
// Long file name assembler for FAT long-name directory entries.
//
// Input channel (in_*): one request per handshake. in_tuser carries the action
// (load entry, clear run, read character, build entry); in_tdata carries the
// entry ordinal byte, checksum, 13 UTF-16 characters, read index and build flag.
// Output channel (out_*): exactly one result per request. out_tuser is the
// status (1 = rejected); out_tdata holds the run state after the request, the
// built entry and the read character.
//
// Characters sit in a row memory, one 13-character row per ordinal, with a
// registered read. The row is read in the accept cycle and modified and
// written back in the execute state once the output register is free; a load
// of a last-in-name entry then passes through a terminator state that writes
// the terminator into the following row through the single write port.
//
// Reset clears the run state and the output valid flag; the name memory is not
// cleared and holds whatever was written. A stalled receiver holds the result
// in the output register; one further request is still taken and waits in the
// execute stage until the register frees.
module long_name_entry_assembler #(
  parameter int unsigned MAX_ORDINAL = lne_pkg::MAX_ORDINAL_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // ordinal_byte, name_checksum, chars_first, chars_second, chars_third,
  // char_last, char_index, build_is_last, zero fill
  input  logic [lne_pkg::IN_W-1:0]  in_tdata,
  // action
  input  logic [1:0]                in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // entry_count, held_ordinal, held_checksum, built_ordinal_byte,
  // built_chars_first, built_chars_second, built_chars_third,
  // built_char_last, read_char, zero fill
  output logic [lne_pkg::OUT_W-1:0] out_tdata,
  // status
  output logic [0:0]                out_tuser
);

  localparam int unsigned ROWS  = MAX_ORDINAL + 1;
  localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned DEPTH = ROWS * lne_pkg::SEG_CHARS;
  localparam logic [7:0]  MAX_ORD8 = 8'(MAX_ORDINAL);
  localparam logic [9:0]  DEPTH10  = 10'(DEPTH);
  localparam logic [lne_pkg::SEG_CHARS-1:0] WE_ALL  = '1;
  localparam logic [lne_pkg::SEG_CHARS-1:0] WE_COL0 = lne_pkg::SEG_CHARS'(1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_TERM = 3'b100
  } state_t;

  // Positions after the first zero character of a segment
  function automatic logic [lne_pkg::SEG_CHARS-1:0] pad_mask(input lne_pkg::seg_t s);
    logic [lne_pkg::SEG_CHARS-1:0] m;
    logic seen;
    m = '0;
    seen = 1'b0;
    for (int c = 0; c < lne_pkg::SEG_CHARS; c++) begin
      m[c] = seen;
      if (s[c] == 16'h0000) seen = 1'b1;
    end
    return m;
  endfunction

  state_t state_r, state_nxt;

  lne_pkg::seg_t mem [ROWS];
  lne_pkg::seg_t rd_r;

  lne_pkg::in_data_t req_r;
  lne_pkg::action_t  act_r;
  logic [3:0]        col_r;
  logic              idx_ok_r;

  logic [4:0] run_ord_r, run_ord_nxt;
  logic [7:0] run_sum_r, run_sum_nxt;
  logic [4:0] run_cnt_r, run_cnt_nxt;

  logic              out_valid_r;
  lne_pkg::out_data_t out_data_r, res;
  logic              out_status_r, res_status;

  // ---- accept side: memory read address ----
  lne_pkg::in_data_t in_d;
  logic              in_acc;
  logic [20:0]       idx_prod;
  logic [5:0]        row_q;
  logic [8:0]        col9;
  logic              idx_ok;
  logic [7:0]        in_ordm1;
  logic              in_ord_ok;
  logic [RW-1:0]     raddr;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_d      = lne_pkg::in_data_t'(in_tdata);

  always_comb begin
    idx_prod  = 21'(in_d.char_index) * 21'(lne_pkg::ROW_RECIP);
    row_q     = idx_prod[lne_pkg::ROW_SHIFT+5:lne_pkg::ROW_SHIFT];
    col9      = in_d.char_index - 9'(row_q) * 9'(lne_pkg::SEG_CHARS);
    idx_ok    = {1'b0, in_d.char_index} < DEPTH10;
    in_ordm1  = in_d.ordinal_byte - 8'd1;
    in_ord_ok = (in_d.ordinal_byte != 8'd0) && (in_d.ordinal_byte <= MAX_ORD8);
    if (lne_pkg::action_t'(in_tuser) == lne_pkg::ACT_READ) begin
      raddr = idx_ok ? row_q[RW-1:0] : '0;
    end else begin
      raddr = in_ord_ok ? in_ordm1[RW-1:0] : '0;
    end
  end

  // ---- execute stage ----
  logic          out_free, exec_go, term_nxt;
  logic [7:0]    ord8, ordm1, bordm1;
  logic          last, ord_ok, bld_ok, bad_pad;
  lne_pkg::seg_t seg_in, padded, bseg;
  logic [lne_pkg::SEG_CHARS-1:0] pm_in, pm_rd, not_pad;
  logic [4:0]    cnt_base;

  logic [lne_pkg::SEG_CHARS-1:0] mem_we;
  logic [RW-1:0]                 mem_waddr;
  lne_pkg::seg_t                 mem_wdata;

  assign out_free = !out_valid_r || out_tready;
  assign exec_go  = (state_r == S_EXEC) && out_free;

  always_comb begin
    ord8   = req_r.ordinal_byte & ~lne_pkg::LAST_FLAG;
    ordm1  = ord8 - 8'd1;
    last   = req_r.ordinal_byte[6];
    ord_ok = (ord8 != 8'd0) && (ord8 <= MAX_ORD8);
    bld_ok = (req_r.ordinal_byte != 8'd0) && (req_r.ordinal_byte <= MAX_ORD8);
    bordm1 = req_r.ordinal_byte - 8'd1;
    seg_in = {req_r.char_last, req_r.chars_third, req_r.chars_second, req_r.chars_first};

    pm_in = pad_mask(seg_in);
    for (int c = 0; c < lne_pkg::SEG_CHARS; c++) begin
      not_pad[c] = (seg_in[c] != lne_pkg::PAD_CHAR);
    end
    bad_pad = |(pm_in & not_pad);

    pm_rd = pad_mask(rd_r);
    for (int c = 0; c < lne_pkg::SEG_CHARS; c++) begin
      padded[c] = pm_rd[c] ? lne_pkg::PAD_CHAR : rd_r[c];
    end
    bseg     = req_r.build_is_last ? padded : rd_r;
    cnt_base = last ? 5'd0 : run_cnt_r;

    run_ord_nxt = run_ord_r;
    run_sum_nxt = run_sum_r;
    run_cnt_nxt = run_cnt_r;
    res_status  = 1'b0;
    term_nxt    = 1'b0;
    mem_we      = '0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    res         = '0;

    unique case (act_r)
      lne_pkg::ACT_LOAD: begin
        priority if (!ord_ok) begin
          run_ord_nxt = '0;
          run_sum_nxt = '0;
          run_cnt_nxt = '0;
          res_status  = 1'b1;
        end else if (!last && run_cnt_r == 5'd0) begin
          // orphan entry: state kept
          res_status = 1'b1;
        end else if (!last && ((ord8[4:0] + 5'd1 != run_ord_r) ||
                               (req_r.name_checksum != run_sum_r))) begin
          run_ord_nxt = '0;
          run_sum_nxt = '0;
          run_cnt_nxt = '0;
          res_status  = 1'b1;
        end else begin
          run_ord_nxt = ord8[4:0];
          run_sum_nxt = req_r.name_checksum;
          mem_we      = WE_ALL;
          mem_waddr   = ordm1[RW-1:0];
          mem_wdata   = seg_in;
          term_nxt    = last;
          if (last && bad_pad) begin
            run_cnt_nxt = '0;
            res_status  = 1'b1;
          end else begin
            run_cnt_nxt = (cnt_base == lne_pkg::COUNT_MAX) ? cnt_base : cnt_base + 5'd1;
          end
        end
      end
      lne_pkg::ACT_CLEAR: begin
        run_ord_nxt = '0;
        run_sum_nxt = '0;
        run_cnt_nxt = '0;
        mem_we      = WE_COL0;
      end
      lne_pkg::ACT_READ: begin
        res.read_char = idx_ok_r ? rd_r[col_r] : 16'h0000;
      end
      lne_pkg::ACT_BUILD: begin
        if (!bld_ok) begin
          res_status = 1'b1;
        end else begin
          res.built_ordinal_byte = req_r.build_is_last ?
                                   (req_r.ordinal_byte | lne_pkg::LAST_FLAG) :
                                   req_r.ordinal_byte;
          res.built_chars_first  = bseg[3:0];
          res.built_chars_second = bseg[7:4];
          res.built_chars_third  = bseg[11:8];
          res.built_char_last    = bseg[12];
          if (req_r.build_is_last) begin
            mem_we    = WE_ALL;
            mem_waddr = bordm1[RW-1:0];
            mem_wdata = padded;
          end
        end
      end
      default: ;
    endcase

    res.entry_count   = run_cnt_nxt;
    res.held_ordinal  = run_ord_nxt;
    res.held_checksum = run_sum_nxt;

    // terminator write into the row after the loaded slot
    if (state_r == S_TERM) begin
      mem_we    = WE_COL0;
      mem_waddr = ord8[RW-1:0];
      mem_wdata = '0;
    end else if (!exec_go) begin
      mem_we = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_EXEC;
      S_EXEC:  if (out_free) state_nxt = term_nxt ? S_TERM : S_IDLE;
      S_TERM:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // name memory: one write port with per-character enables, one read port
  always_ff @(posedge clk) begin
    for (int c = 0; c < lne_pkg::SEG_CHARS; c++) begin
      if (mem_we[c]) mem[mem_waddr][c] <= mem_wdata[c];
    end
    if (in_acc) rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r    <= in_d;
      act_r    <= lne_pkg::action_t'(in_tuser);
      col_r    <= col9[3:0];
      idx_ok_r <= idx_ok;
    end
    if (exec_go) begin
      out_data_r   <= res;
      out_status_r <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_ord_r   <= '0;
      run_sum_r   <= '0;
      run_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_go) begin
        run_ord_r <= run_ord_nxt;
        run_sum_r <= run_sum_nxt;
        run_cnt_r <= run_cnt_nxt;
      end
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_status_r;

endmodule

@@ rtl/lne_checker.sv @@
module lne_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic [lne_pkg::IN_W-1:0]  in_tdata,
  input logic [1:0]                in_tuser,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [lne_pkg::OUT_W-1:0] out_tdata,
  input logic [0:0]                out_tuser
);

  lne_pkg::out_data_t od;
  assign od = lne_pkg::out_data_t'(out_tdata);

  // one request at a time: busy in the cycle after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted on back-to-back cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

  // rejected requests carry neither built entry nor read data
  a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (od.built_ordinal_byte == 8'd0 && od.read_char == 16'd0))
    else $error("rejected result carries data");

  // a read result never carries a built entry
  a_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && od.read_char != 16'd0) |->
      (od.built_ordinal_byte == 8'd0 && od.built_char_last == 16'd0 && !out_tuser[0]))
    else $error("read and build data mixed");

endmodule

bind long_name_entry_assembler lne_checker u_lne_checker (.*);
